[hw/rtl/gps_pkg.sv]
// Package for the grid path search block: payload structs, register and
// status codes, the step table and the heuristic table.
// No dependencies.
`default_nettype none

package gps_pkg;

  localparam int COORD_W = 3;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W = 4;
  localparam int HW = 20;
  localparam int PATH_DEPTH = 64;
  localparam int PATH_AW = 6;
  localparam int SQ_W = 7;

  localparam int DEF_MAX_COLS = 8;
  localparam int DEF_MAX_ROWS = 8;
  localparam int DEF_NODE_DEPTH = 256;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 4'd1;
  localparam logic [CFG_W-1:0] GRID_SIZE_RESET = 4'd8;

  localparam logic [1:0] STATUS_PATH = 2'd0;
  localparam logic [1:0] STATUS_NO_PATH = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  localparam logic REQ_SET = 1'b0;

  // Neighbour order +y, +x, -y, -x as four-bit two's complement deltas.
  localparam logic [3:0] STEP_DX [0:3] = '{4'd0, 4'd1, 4'd0, 4'hF};
  localparam logic [3:0] STEP_DY [0:3] = '{4'd1, 4'd0, 4'hF, 4'd0};

  typedef struct packed {
    logic               req_type;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] goal_x;
    logic [COORD_W-1:0] goal_y;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] path_x;
    logic [COORD_W-1:0] path_y;
    logic [1:0]         status;
    logic               last;
  } out_item_t;

  typedef logic [HW-1:0] heur_tab_t [0:(1<<SQ_W)-1];

  // Rounded sqrt(s) in Q4.16 for every squared distance s, built at
  // elaboration with the usual digit-by-digit square root.
  function automatic heur_tab_t build_heur_tab();
    heur_tab_t   t;
    logic [63:0] n;
    logic [63:0] nn;
    logic [63:0] r;
    logic [63:0] b;
    for (int s = 0; s < (1 << SQ_W); s++) begin
      n = 64'(s) << 32;
      nn = n;
      r = 64'd0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
        if (b > nn) b = b >> 2;
      end
      for (int i = 0; i < 32; i++) begin
        if (b != 64'd0) begin
          if (nn >= r + b) begin
            nn = nn - (r + b);
            r = (r >> 1) + b;
          end else begin
            r = r >> 1;
          end
          b = b >> 2;
        end
      end
      if (n - r * r > r) r = r + 64'd1;
      t[s] = r[HW-1:0];
    end
    return t;
  endfunction

  localparam heur_tab_t HEUR_TAB = build_heur_tab();

endpackage

`default_nettype wire

[hw/rtl/grid_path_search.sv]
// Grid path search: obstacle map and 4-connected A* search with path output.
// Depends on gps_pkg.
//
// Usage: items arrive on in_valid/in_ready with an in_item_t payload. A set
// beat marks one obstacle cell and leaves the block idle, so sets can follow back
// to back. A search beat runs A* and returns the path from start to goal as
// out_item_t beats on out_valid/out_ready, the goal beat carrying last; a
// failed search returns a single flagged beat. Grid size is written on
// cfg_valid/cfg_ready (index, data) while the block is idle; cfg_ready is
// always high.
// Flow: the node and open-list memories have one read port each, so every
// expansion costs one pass over the open list, the list compaction (the
// entries after the chosen one shift down one place), and a visit to each
// neighbour, a free one adding a pass over the open list and, when it is
// pushed, a heuristic lookup and a node and open-list write. The path walk
// reads one node record per cell and stores it in the path buffer.
// Reset clears the obstacle map, the counters and the grid size (8x8);
// there is no clearing pass. in_ready is high only when idle, and a
// stalled result beat simply holds the block until it is taken.
`default_nettype none

module grid_path_search #(
  parameter int MAX_COLS = gps_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = gps_pkg::DEF_MAX_ROWS,
  parameter int NODE_DEPTH = gps_pkg::DEF_NODE_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire gps_pkg::in_item_t            in_item,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output gps_pkg::out_item_t                out_item,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [gps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gps_pkg::CFG_W-1:0]    cfg_data
);
  import gps_pkg::*;

  localparam int NW = $clog2(NODE_DEPTH);
  localparam int CELLS = MAX_COLS * MAX_ROWS;
  localparam int CIW = $clog2(CELLS);
  localparam int NODE_W = 2 * COORD_W + 2 * NW + HW;
  localparam int FW = NW + 17;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INIT     = 4'd1;
  localparam logic [3:0] S_SCAN_MIN = 4'd2;
  localparam logic [3:0] S_REMOVE   = 4'd3;
  localparam logic [3:0] S_NEIGH    = 4'd4;
  localparam logic [3:0] S_SCAN_DUP = 4'd5;
  localparam logic [3:0] S_HEUR     = 4'd6;
  localparam logic [3:0] S_PUSH     = 4'd7;
  localparam logic [3:0] S_NEXT     = 4'd8;
  localparam logic [3:0] S_PATH_RD  = 4'd9;
  localparam logic [3:0] S_PATH_WT  = 4'd10;
  localparam logic [3:0] S_OUT_RD   = 4'd11;
  localparam logic [3:0] S_OUT_LD   = 4'd12;
  localparam logic [3:0] S_OUT_WAIT = 4'd13;

  function automatic logic in_grid(input logic [3:0] x, input logic [3:0] y,
                                   input logic [3:0] w, input logic [3:0] h);
    return (x < w) && (x < 4'(MAX_COLS)) && (y < h) && (y < 4'(MAX_ROWS));
  endfunction

  function automatic logic [CIW-1:0] cell_idx(input logic [COORD_W-1:0] x,
                                              input logic [COORD_W-1:0] y);
    return CIW'(32'(y) * MAX_COLS + 32'(x));
  endfunction

  logic [3:0]         state;
  logic [CFG_W-1:0]   grid_width;
  logic [CFG_W-1:0]   grid_height;
  logic [CELLS-1:0]   obstacle_map;
  logic [CELLS-1:0]   closed_map;

  logic [COORD_W-1:0] sx, sy, gx, gy;
  logic [NW:0]        open_count;
  logic [NW:0]        node_count;

  logic [NW:0]        k_issue;
  logic               s1_v, s2_v;
  logic [NW-1:0]      s1_k, s2_k, s2_id;

  logic [NW-1:0]      best_k, best_id;
  logic [FW-1:0]      best_f;
  logic [COORD_W-1:0] cur_x, cur_y;
  logic [NW-1:0]      cur_g;
  logic               blocked;

  logic [NW:0]        rm_j;
  logic               rm_v;
  logic [NW-1:0]      rm_wa;

  logic [1:0]         dir;
  logic [COORD_W-1:0] nbr_x, nbr_y;
  logic [HW-1:0]      heur;

  logic [NW-1:0]      path_n;
  logic [PATH_AW:0]   path_len;
  logic [PATH_AW:0]   out_k;

  // Memories.
  logic [NODE_W-1:0]  node_mem [0:NODE_DEPTH-1];
  logic [NW-1:0]      open_mem [0:NODE_DEPTH-1];
  logic [2*COORD_W-1:0] path_mem [0:PATH_DEPTH-1];

  logic               node_we, open_we, path_we;
  logic [NW-1:0]      node_wa, node_ra, open_wa, open_ra;
  logic [NODE_W-1:0]  node_wd, node_rdata;
  logic [NW-1:0]      open_wd, open_rdata;
  logic [PATH_AW-1:0] path_wa, path_ra;
  logic [2*COORD_W-1:0] path_wd, path_rdata;

  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_wa] <= node_wd;
    node_rdata <= node_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (open_we) open_mem[open_wa] <= open_wd;
    open_rdata <= open_mem[open_ra];
  end

  always_ff @(posedge clk) begin
    if (path_we) path_mem[path_wa] <= path_wd;
    path_rdata <= path_mem[path_ra];
  end

  // Node record fields as read back.
  logic [COORD_W-1:0] nd_x, nd_y;
  logic [NW-1:0]      nd_g, nd_parent;
  logic [HW-1:0]      nd_h;
  logic [FW-1:0]      f_cur;
  logic [NW-1:0]      new_g;

  assign nd_x      = node_rdata[NODE_W-1 -: COORD_W];
  assign nd_y      = node_rdata[NODE_W-COORD_W-1 -: COORD_W];
  assign nd_g      = node_rdata[2*NW+HW-1 -: NW];
  assign nd_h      = node_rdata[NW+HW-1 -: HW];
  assign nd_parent = node_rdata[NW-1:0];
  assign f_cur     = FW'({nd_g, 16'h0000}) + FW'(nd_h);
  assign new_g     = cur_g + NW'(1);

  // Neighbour under test.
  logic [3:0]         nx, ny;
  logic               nb_ok;
  logic [CIW-1:0]     nb_idx, cur_idx, set_idx;
  logic [COORD_W-1:0] adx, ady;
  logic [SQ_W-1:0]    dist_sq;

  assign nx      = {1'b0, cur_x} + STEP_DX[dir];
  assign ny      = {1'b0, cur_y} + STEP_DY[dir];
  assign nb_idx  = cell_idx(nx[COORD_W-1:0], ny[COORD_W-1:0]);
  assign nb_ok   = in_grid(nx, ny, grid_width, grid_height) &&
                   !obstacle_map[nb_idx] && !closed_map[nb_idx];
  assign cur_idx = cell_idx(cur_x, cur_y);
  assign set_idx = cell_idx(in_item.cell_x, in_item.cell_y);
  assign adx     = (nbr_x > gx) ? nbr_x - gx : gx - nbr_x;
  assign ady     = (nbr_y > gy) ? nbr_y - gy : gy - nbr_y;
  assign dist_sq = SQ_W'(6'(adx) * 6'(adx)) + SQ_W'(6'(ady) * 6'(ady));

  logic scan_done, rm_done;
  assign scan_done = (k_issue >= open_count) && !s1_v && !s2_v;
  assign rm_done   = (rm_j >= open_count) && !rm_v;

  always_comb begin
    node_we = 1'b0;
    node_wa = node_count[NW-1:0];
    node_wd = {nbr_x, nbr_y, new_g, heur, best_id};
    node_ra = path_n;
    open_we = 1'b0;
    open_wa = open_count[NW-1:0];
    open_wd = node_count[NW-1:0];
    open_ra = k_issue[NW-1:0];
    path_we = 1'b0;
    path_wa = path_len[PATH_AW-1:0];
    path_wd = {nd_y, nd_x};
    path_ra = PATH_AW'(out_k - 1'b1);
    case (state)
      S_INIT: begin
        node_we = 1'b1;
        node_wa = '0;
        node_wd = {sx, sy, {NW{1'b0}}, {HW{1'b0}}, {NW{1'b0}}};
        open_we = 1'b1;
        open_wa = '0;
        open_wd = '0;
      end
      S_SCAN_MIN, S_SCAN_DUP: begin
        node_ra = open_rdata;
      end
      S_REMOVE: begin
        open_ra = rm_j[NW-1:0];
        open_we = rm_v;
        open_wa = rm_wa;
        open_wd = open_rdata;
      end
      S_PUSH: begin
        node_we = 1'b1;
        open_we = 1'b1;
      end
      S_PATH_WT: begin
        path_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      grid_width   <= GRID_SIZE_RESET;
      grid_height  <= GRID_SIZE_RESET;
      obstacle_map <= '0;
      closed_map   <= '0;
      open_count   <= '0;
      node_count   <= '0;
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      rm_v         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_GRID_WIDTH) grid_width <= cfg_data;
        else if (cfg_index == REG_GRID_HEIGHT) grid_height <= cfg_data;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_item.req_type == REQ_SET) begin
              if (in_grid({1'b0, in_item.cell_x}, {1'b0, in_item.cell_y},
                          grid_width, grid_height)) begin
                obstacle_map[set_idx] <= 1'b1;
              end
            end else begin
              sx <= in_item.start_x;
              sy <= in_item.start_y;
              gx <= in_item.goal_x;
              gy <= in_item.goal_y;
              if (in_grid({1'b0, in_item.start_x}, {1'b0, in_item.start_y},
                          grid_width, grid_height)) begin
                state <= S_INIT;
              end else begin
                out_item  <= '{path_x: '0, path_y: '0, status: STATUS_NO_PATH,
                               last: 1'b1};
                out_valid <= 1'b1;
                out_k     <= '0;
                state     <= S_OUT_WAIT;
              end
            end
          end
        end

        S_INIT: begin
          closed_map <= '0;
          node_count <= (NW+1)'(1);
          open_count <= (NW+1)'(1);
          k_issue    <= '0;
          state      <= S_SCAN_MIN;
        end

        S_SCAN_MIN, S_SCAN_DUP: begin
          // Three-deep pipeline: open list read, node read, evaluate.
          if (k_issue < open_count) begin
            s1_v    <= 1'b1;
            k_issue <= k_issue + 1'b1;
          end else begin
            s1_v <= 1'b0;
          end
          s1_k  <= k_issue[NW-1:0];
          s2_v  <= s1_v;
          s2_k  <= s1_k;
          s2_id <= open_rdata;
          if (s2_v) begin
            if (state == S_SCAN_MIN) begin
              if (s2_k == '0 || f_cur < best_f) begin
                best_f  <= f_cur;
                best_k  <= s2_k;
                best_id <= s2_id;
                cur_x   <= nd_x;
                cur_y   <= nd_y;
                cur_g   <= nd_g;
              end
            end else if (nd_x == nbr_x && nd_y == nbr_y && new_g >= nd_g) begin
              blocked <= 1'b1;
            end
          end
          if (scan_done) begin
            if (state == S_SCAN_MIN) begin
              rm_j  <= (NW+1)'(best_k) + 1'b1;
              rm_v  <= 1'b0;
              state <= S_REMOVE;
            end else if (blocked) begin
              state <= S_NEXT;
            end else if (node_count >= (NW+1)'(NODE_DEPTH) ||
                         open_count >= (NW+1)'(NODE_DEPTH)) begin
              out_item  <= '{path_x: '0, path_y: '0, status: STATUS_OVERFLOW,
                             last: 1'b1};
              out_valid <= 1'b1;
              out_k     <= '0;
              state     <= S_OUT_WAIT;
            end else begin
              state <= S_HEUR;
            end
          end
        end

        S_REMOVE: begin
          // Close the gap left by the chosen entry, one entry per cycle.
          if (rm_j < open_count) begin
            rm_v  <= 1'b1;
            rm_wa <= rm_j[NW-1:0] - NW'(1);
            rm_j  <= rm_j + 1'b1;
          end else begin
            rm_v <= 1'b0;
          end
          if (rm_done) begin
            open_count           <= open_count - 1'b1;
            closed_map[cur_idx]  <= 1'b1;
            if (cur_x == gx && cur_y == gy) begin
              path_n   <= best_id;
              path_len <= '0;
              state    <= S_PATH_RD;
            end else begin
              dir   <= '0;
              state <= S_NEIGH;
            end
          end
        end

        S_NEIGH: begin
          if (nb_ok) begin
            nbr_x   <= nx[COORD_W-1:0];
            nbr_y   <= ny[COORD_W-1:0];
            k_issue <= '0;
            blocked <= 1'b0;
            state   <= S_SCAN_DUP;
          end else begin
            state <= S_NEXT;
          end
        end

        S_HEUR: begin
          heur  <= HEUR_TAB[dist_sq];
          state <= S_PUSH;
        end

        S_PUSH: begin
          node_count <= node_count + 1'b1;
          open_count <= open_count + 1'b1;
          state      <= S_NEXT;
        end

        S_NEXT: begin
          if (dir == 2'd3) begin
            if (open_count == '0) begin
              out_item  <= '{path_x: '0, path_y: '0, status: STATUS_NO_PATH,
                             last: 1'b1};
              out_valid <= 1'b1;
              out_k     <= '0;
              state     <= S_OUT_WAIT;
            end else begin
              k_issue <= '0;
              state   <= S_SCAN_MIN;
            end
          end else begin
            dir   <= dir + 1'b1;
            state <= S_NEIGH;
          end
        end

        S_PATH_RD: begin
          state <= S_PATH_WT;
        end

        S_PATH_WT: begin
          // The cell is written to the path buffer by the comb write port.
          path_len <= path_len + 1'b1;
          if (path_n == '0 || path_len == (PATH_AW+1)'(PATH_DEPTH - 1)) begin
            out_k <= path_len + 1'b1;
            state <= S_OUT_RD;
          end else begin
            path_n <= nd_parent;
            state  <= S_PATH_RD;
          end
        end

        S_OUT_RD: begin
          state <= S_OUT_LD;
        end

        S_OUT_LD: begin
          out_item  <= '{path_x: path_rdata[COORD_W-1:0],
                         path_y: path_rdata[2*COORD_W-1:COORD_W],
                         status: STATUS_PATH,
                         last: (out_k == (PATH_AW+1)'(1))};
          out_valid <= 1'b1;
          out_k     <= out_k - 1'b1;
          state     <= S_OUT_WAIT;
        end

        S_OUT_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= (out_k == '0) ? S_IDLE : S_OUT_RD;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/gps_checker.sv]
// Port-level checks for the grid path search block, bound to its top level.
// Depends on gps_pkg and grid_path_search.
`default_nettype none

module gps_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire gps_pkg::in_item_t  in_item,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire gps_pkg::out_item_t out_item
);
  import gps_pkg::*;

  // A result beat held back by the receiver keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result beat changed while stalled");

  // An obstacle write never produces a result.
  a_set_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_item.req_type == REQ_SET |=> !out_valid)
    else $error("result after obstacle write");

  // A flagged result is a single, final, zeroed beat.
  a_flag_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != STATUS_PATH |->
      out_item.last && out_item.path_x == '0 && out_item.path_y == '0)
    else $error("flagged result malformed");

  // No new request is taken while a result is pending.
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input accepted while delivering results");

endmodule

bind grid_path_search gps_checker u_gps_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_item  (in_item),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_item (out_item)
);

`default_nettype wire
